// ----- design/pdna_pkg.sv -----
package pdna_pkg;

    localparam int MAX_BASES_DEF = 4096;
    localparam int POS_W         = 13;
    localparam int MPOS_W        = POS_W + 1;
    localparam int CHAR_W        = 8;
    localparam int LETTER_W      = 7;
    localparam int LEN_W         = 13;
    localparam int CODE_W        = 2;
    localparam int Q_DEPTH       = 2;

    localparam logic RES_READ  = 1'b0;
    localparam logic RES_MATCH = 1'b1;

    typedef enum logic [1:0] {
        ACT_WRITE = 2'd0,
        ACT_READ  = 2'd1,
        ACT_MATCH = 2'd2,
        ACT_CLEAR = 2'd3
    } t_action;

    typedef struct packed {
        t_action                  action;
        logic signed [POS_W-1:0]  pos;
        logic                     pos_ok;
        logic [CODE_W-1:0]        code;
        logic [CHAR_W-1:0]        ch;
        logic                     comp;
        logic                     desc;
        logic                     first;
        logic                     last;
    } t_item;

    function automatic logic [CODE_W-1:0] code_of(input logic [CHAR_W-1:0] ch);
        logic [CODE_W-1:0] code;
        unique case (ch)
            8'h43, 8'h63: code = 2'd1;
            8'h47, 8'h67: code = 2'd2;
            8'h54, 8'h74: code = 2'd3;
            default:      code = 2'd0;
        endcase
        return code;
    endfunction

    function automatic logic [LETTER_W-1:0] letter_of(input logic [CODE_W-1:0] code);
        logic [LETTER_W-1:0] letter;
        unique case (code)
            2'd0: letter = 7'h41;
            2'd1: letter = 7'h43;
            2'd2: letter = 7'h47;
            2'd3: letter = 7'h54;
            default: letter = 7'h41;
        endcase
        return letter;
    endfunction

endpackage

// ----- design/packed_dna_store_match.sv -----
// Packed DNA store with streamed matching.
// Input channel (i_valid / o_stall): one beat per action - write a base, read a
// base, stream one match character, or clear the length. A beat is taken at a
// rising edge with i_valid high and o_stall low.
// Output channel (o_valid / i_stall): one beat per read and per match
// character that ends a run; writes, clears and other match characters give none.
// Path: a beat waits in the queue, is popped with its store read issued, then
// is looked up, and its result is registered in the output register.
// Flow: writes and clears finish on issue; reads and match characters also take
// a lookup step, and no new beat is popped meanwhile. The store has a single port
// with a registered read; the next match character needs the position left behind.
// Reset: synchronous, active low. After it the store is swept to base A one
// entry per cycle, over all MAX_BASES entries, with o_stall held high the whole time.
// Receiver stall: the finished result is held in the output register; the back
// end waits with the next result, and the two-deep queue absorbs input beats
// until it fills, then o_stall rises.
module packed_dna_store_match #(
    parameter int MAX_BASES = pdna_pkg::MAX_BASES_DEF
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_valid,
    output logic                                 o_stall,
    input  logic [1:0]                           i_action,
    input  logic signed [pdna_pkg::POS_W-1:0]    i_position,
    input  logic [pdna_pkg::CHAR_W-1:0]          i_base_char,
    input  logic                                 i_complement,
    input  logic                                 i_descending,
    input  logic                                 i_first_of_run,
    input  logic                                 i_last_of_run,
    output logic                                 o_valid,
    input  logic                                 i_stall,
    output logic                                 o_result_kind,
    output logic [pdna_pkg::LETTER_W-1:0]        o_base_out,
    output logic [pdna_pkg::LEN_W-1:0]           o_match_length
);

    // front to queue
    logic            push;
    pdna_pkg::t_item push_item;
    logic            q_full;

    // queue to back
    logic            q_empty;
    logic            pop;
    pdna_pkg::t_item pop_item;

    // back end busy with its clearing sweep
    logic            clearing;

    // Classify the beat: decode action, range-check position, encode the base.
    pdna_front #(
        .MAX_BASES (MAX_BASES)
    ) u_front (
        .i_valid        (i_valid),
        .o_stall        (o_stall),
        .i_action       (i_action),
        .i_position     (i_position),
        .i_base_char    (i_base_char),
        .i_complement   (i_complement),
        .i_descending   (i_descending),
        .i_first_of_run (i_first_of_run),
        .i_last_of_run  (i_last_of_run),
        .i_q_full       (q_full),
        .i_clearing     (clearing),
        .o_push         (push),
        .o_item         (push_item)
    );

    // Decouple the front from the back so either side can stall alone.
    pdna_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_item  (push_item),
        .o_full  (q_full),
        .i_pop   (pop),
        .o_empty (q_empty),
        .o_item  (pop_item)
    );

    // Own the store, the length and the match run; register results.
    pdna_back #(
        .MAX_BASES (MAX_BASES)
    ) u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_q_empty      (q_empty),
        .i_item         (pop_item),
        .o_pop          (pop),
        .o_clearing     (clearing),
        .o_valid        (o_valid),
        .i_stall        (i_stall),
        .o_result_kind  (o_result_kind),
        .o_base_out     (o_base_out),
        .o_match_length (o_match_length)
    );

endmodule

// ----- design/pdna_front.sv -----
module pdna_front #(
    parameter int MAX_BASES = pdna_pkg::MAX_BASES_DEF
) (
    input  logic                                 i_valid,
    output logic                                 o_stall,
    input  logic [1:0]                           i_action,
    input  logic signed [pdna_pkg::POS_W-1:0]    i_position,
    input  logic [pdna_pkg::CHAR_W-1:0]          i_base_char,
    input  logic                                 i_complement,
    input  logic                                 i_descending,
    input  logic                                 i_first_of_run,
    input  logic                                 i_last_of_run,
    input  logic                                 i_q_full,
    input  logic                                 i_clearing,
    output logic                                 o_push,
    output pdna_pkg::t_item                      o_item
);

    logic pos_ok;

    // position is inside the store when non-negative and below the depth
    assign pos_ok = !i_position[pdna_pkg::POS_W-1] &&
                    (32'(i_position[pdna_pkg::POS_W-2:0]) < 32'(MAX_BASES));

    assign o_stall = i_q_full || i_clearing;
    assign o_push  = i_valid && !o_stall;

    always_comb begin
        o_item.action = pdna_pkg::t_action'(i_action);
        o_item.pos    = i_position;
        o_item.pos_ok = pos_ok;
        o_item.code   = pdna_pkg::code_of(i_base_char) ^ {pdna_pkg::CODE_W{i_complement}};
        o_item.ch     = i_base_char;
        o_item.comp   = i_complement;
        o_item.desc   = i_descending;
        o_item.first  = i_first_of_run;
        o_item.last   = i_last_of_run;
    end

endmodule

// ----- design/pdna_queue.sv -----
module pdna_queue (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_push,
    input  pdna_pkg::t_item i_item,
    output logic            o_full,
    input  logic            i_pop,
    output logic            o_empty,
    output pdna_pkg::t_item o_item
);

    localparam int PW = (pdna_pkg::Q_DEPTH > 1) ? $clog2(pdna_pkg::Q_DEPTH) : 1;
    localparam int CW = $clog2(pdna_pkg::Q_DEPTH + 1);

    pdna_pkg::t_item r_slot [pdna_pkg::Q_DEPTH];
    logic [PW-1:0]   r_wr_ptr, n_wr_ptr;
    logic [PW-1:0]   r_rd_ptr, n_rd_ptr;
    logic [CW-1:0]   r_count, n_count;
    logic            do_push, do_pop;

    assign o_full  = (r_count == CW'(pdna_pkg::Q_DEPTH));
    assign o_empty = (r_count == '0);
    assign o_item  = r_slot[r_rd_ptr];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (do_push) begin
            n_wr_ptr = (r_wr_ptr == PW'(pdna_pkg::Q_DEPTH - 1)) ? '0 : r_wr_ptr + PW'(1);
        end
        if (do_pop) begin
            n_rd_ptr = (r_rd_ptr == PW'(pdna_pkg::Q_DEPTH - 1)) ? '0 : r_rd_ptr + PW'(1);
        end
        if (do_push && !do_pop) begin
            n_count = r_count + CW'(1);
        end else if (do_pop && !do_push) begin
            n_count = r_count - CW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_slot[r_wr_ptr] <= i_item;
        end
    end

endmodule

// ----- design/pdna_back.sv -----
module pdna_back #(
    parameter int MAX_BASES = pdna_pkg::MAX_BASES_DEF
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_q_empty,
    input  pdna_pkg::t_item                     i_item,
    output logic                                o_pop,
    output logic                                o_clearing,
    output logic                                o_valid,
    input  logic                                i_stall,
    output logic                                o_result_kind,
    output logic [pdna_pkg::LETTER_W-1:0]       o_base_out,
    output logic [pdna_pkg::LEN_W-1:0]          o_match_length
);

    localparam int AW = (MAX_BASES > 1) ? $clog2(MAX_BASES) : 1;
    localparam int PB = pdna_pkg::POS_W - 1;

    typedef enum logic [2:0] {
        ST_CLEAR = 3'b001,
        ST_RUN   = 3'b010,
        ST_LOOK  = 3'b100
    } t_state;

    logic [pdna_pkg::CODE_W-1:0]        r_mem [MAX_BASES];
    logic [pdna_pkg::CODE_W-1:0]        r_rd_data;

    t_state                             r_state, n_state;
    logic [AW-1:0]                      r_clr_addr, n_clr_addr;
    logic [pdna_pkg::LEN_W-1:0]         r_seq_len, n_seq_len;
    logic signed [pdna_pkg::MPOS_W-1:0] r_match_pos, n_match_pos;
    logic [pdna_pkg::LEN_W-1:0]         r_count, n_count;
    logic                               r_stopped, n_stopped;
    pdna_pkg::t_item                    r_cur;

    logic                               r_o_valid, n_o_valid;
    logic                               r_kind, n_kind;
    logic [pdna_pkg::LETTER_W-1:0]      r_base, n_base;
    logic [pdna_pkg::LEN_W-1:0]         r_len, n_len;

    logic                               mem_we;
    logic [AW-1:0]                      mem_wa;
    logic [pdna_pkg::CODE_W-1:0]        mem_wd;
    logic                               rd_en;
    logic [AW-1:0]                      rd_addr;
    logic signed [pdna_pkg::MPOS_W-1:0] eff_pos;
    logic [pdna_pkg::LEN_W-1:0]         wr_end;
    logic                               out_free;
    logic                               m_in;
    logic [pdna_pkg::CODE_W-1:0]        m_code;
    logic                               m_hit;

    assign out_free   = !r_o_valid || !i_stall;
    assign o_clearing = (r_state == ST_CLEAR);
    assign o_valid        = r_o_valid;
    assign o_result_kind  = r_kind;
    assign o_base_out     = r_base;
    assign o_match_length = r_len;

    assign eff_pos = i_item.first ? {i_item.pos[PB], i_item.pos} : r_match_pos;
    assign rd_addr = (i_item.action == pdna_pkg::ACT_MATCH) ?
                     AW'(eff_pos[PB-1:0]) : AW'(i_item.pos[PB-1:0]);
    assign wr_end  = pdna_pkg::LEN_W'({1'b0, i_item.pos[PB-1:0]}) + pdna_pkg::LEN_W'(1);

    assign m_in   = !r_match_pos[pdna_pkg::MPOS_W-1] &&
                    (r_match_pos[pdna_pkg::LEN_W-1:0] < r_seq_len);
    assign m_code = r_rd_data ^ {pdna_pkg::CODE_W{r_cur.comp}};
    assign m_hit  = ({1'b0, pdna_pkg::letter_of(m_code)} == r_cur.ch);

    always_comb begin
        n_state     = r_state;
        n_clr_addr  = r_clr_addr;
        n_seq_len   = r_seq_len;
        n_match_pos = r_match_pos;
        n_count     = r_count;
        n_stopped   = r_stopped;
        n_o_valid   = r_o_valid && i_stall;
        n_kind      = r_kind;
        n_base      = r_base;
        n_len       = r_len;
        o_pop       = 1'b0;
        mem_we      = 1'b0;
        mem_wa      = i_item.pos[AW-1:0];
        mem_wd      = i_item.code;
        rd_en       = 1'b0;

        unique case (r_state)
            ST_CLEAR: begin
                // sweep the store to base A, one entry a cycle
                mem_we     = 1'b1;
                mem_wa     = r_clr_addr;
                mem_wd     = '0;
                n_clr_addr = r_clr_addr + AW'(1);
                if (r_clr_addr == AW'(MAX_BASES - 1)) begin
                    n_state = ST_RUN;
                end
            end
            ST_RUN: begin
                if (!i_q_empty) begin
                    o_pop = 1'b1;
                    unique case (i_item.action)
                        pdna_pkg::ACT_WRITE: begin
                            if (i_item.pos_ok) begin
                                mem_we = 1'b1;
                                mem_wa = AW'(i_item.pos[PB-1:0]);
                                if (wr_end > r_seq_len) begin
                                    n_seq_len = wr_end;
                                end
                            end
                        end
                        pdna_pkg::ACT_CLEAR: begin
                            n_seq_len = '0;
                        end
                        pdna_pkg::ACT_READ: begin
                            rd_en   = i_item.pos_ok;
                            n_state = ST_LOOK;
                        end
                        pdna_pkg::ACT_MATCH: begin
                            // start a new run before the lookup
                            if (i_item.first) begin
                                n_match_pos = eff_pos;
                                n_count     = '0;
                                n_stopped   = 1'b0;
                            end
                            rd_en   = 1'b1;
                            n_state = ST_LOOK;
                        end
                        default: ;
                    endcase
                end
            end
            ST_LOOK: begin
                if (r_cur.action == pdna_pkg::ACT_READ) begin
                    if (out_free) begin
                        n_o_valid = 1'b1;
                        n_kind    = pdna_pkg::RES_READ;
                        n_base    = r_cur.pos_ok ? pdna_pkg::letter_of(r_rd_data) :
                                                   pdna_pkg::letter_of('0);
                        n_len     = '0;
                        n_state   = ST_RUN;
                    end
                end else if (!r_cur.last || out_free) begin
                    if (!r_stopped) begin
                        if (!m_in || !m_hit) begin
                            n_stopped = 1'b1;
                        end else begin
                            n_count     = r_count + pdna_pkg::LEN_W'(1);
                            n_match_pos = r_cur.desc ? r_match_pos - pdna_pkg::MPOS_W'(1) :
                                                       r_match_pos + pdna_pkg::MPOS_W'(1);
                        end
                    end
                    if (r_cur.last) begin
                        n_stopped = 1'b1;
                        n_o_valid = 1'b1;
                        n_kind    = pdna_pkg::RES_MATCH;
                        n_base    = pdna_pkg::letter_of('0);
                        n_len     = (!r_stopped && m_in && m_hit) ?
                                    r_count + pdna_pkg::LEN_W'(1) : r_count;
                    end
                    n_state = ST_RUN;
                end
            end
            default: begin
                n_state = ST_CLEAR;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_CLEAR;
            r_clr_addr  <= '0;
            r_seq_len   <= '0;
            r_match_pos <= '0;
            r_count     <= '0;
            r_stopped   <= 1'b0;
            r_o_valid   <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_clr_addr  <= n_clr_addr;
            r_seq_len   <= n_seq_len;
            r_match_pos <= n_match_pos;
            r_count     <= n_count;
            r_stopped   <= n_stopped;
            r_o_valid   <= n_o_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_kind <= n_kind;
        r_base <= n_base;
        r_len  <= n_len;
        if (o_pop) begin
            r_cur <= i_item;
        end
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[mem_wa] <= mem_wd;
        end
        if (rd_en) begin
            r_rd_data <= r_mem[rd_addr];
        end
    end

`ifndef SYNTHESIS
    a_no_pop_while_clearing: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_CLEAR) |-> (!o_pop && !mem_we || mem_wa == r_clr_addr))
        else $error("item taken during store clearing pass");

    a_result_waits: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_LOOK && r_cur.action == pdna_pkg::ACT_MATCH && r_cur.last &&
         !out_free) |=> (r_state == ST_LOOK && $stable(r_count) && $stable(r_match_pos)))
        else $error("match run state changed while its result was blocked");

    a_write_extends: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_pop && i_item.action == pdna_pkg::ACT_WRITE && i_item.pos_ok) |=>
        (r_seq_len != '0))
        else $error("in-range write left the sequence length at zero");

    a_count_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_pop && i_item.action != pdna_pkg::ACT_MATCH) |=> $stable(r_count))
        else $error("match count moved on a non-match beat");
`endif

endmodule

// ----- test/tb_packed_dna_store_match.sv -----
module tb_packed_dna_store_match;
    import pdna_pkg::*;

    localparam int DEPTH        = MAX_BASES_DEF;
    localparam int IDLE_PCT     = 27;
    // Long enough that the two-deep queue fills and the input stalls.
    localparam int HOLD_CYCLES  = 300;
    // Covers the post-reset sweep of the store (DEPTH entries, input stalled)
    // and the long receiver hold, several times over.
    localparam int STALL_LIMIT  = 20000;
    // Margin after the last expected result has come back.
    localparam int DRAIN_CYCLES = 20;
    localparam int MAX_PRINTS   = 200;

    logic                      i_clk;
    logic                      i_rst_n;
    logic                      i_valid;
    logic                      o_stall;
    logic [1:0]                i_action;
    logic signed [POS_W-1:0]   i_position;
    logic [CHAR_W-1:0]         i_base_char;
    logic                      i_complement;
    logic                      i_descending;
    logic                      i_first_of_run;
    logic                      i_last_of_run;
    logic                      o_valid;
    logic                      i_stall;
    logic                      o_result_kind;
    logic [LETTER_W-1:0]       o_base_out;
    logic [LEN_W-1:0]          o_match_length;

    packed_dna_store_match #(
        .MAX_BASES(DEPTH)
    ) i_dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (i_valid),
        .o_stall        (o_stall),
        .i_action       (i_action),
        .i_position     (i_position),
        .i_base_char    (i_base_char),
        .i_complement   (i_complement),
        .i_descending   (i_descending),
        .i_first_of_run (i_first_of_run),
        .i_last_of_run  (i_last_of_run),
        .o_valid        (o_valid),
        .i_stall        (i_stall),
        .o_result_kind  (o_result_kind),
        .o_base_out     (o_base_out),
        .o_match_length (o_match_length)
    );

    // One input beat, one field per port.
    typedef struct {
        t_action                 act;
        logic signed [POS_W-1:0] pos;
        logic [CHAR_W-1:0]       ch;
        logic                    comp;
        logic                    desc;
        logic                    first;
        logic                    last;
    } dna_beat_t;

    // One output beat: a read letter or a match count.
    typedef struct {
        logic                kind;
        logic [LETTER_W-1:0] letter;
        logic [LEN_W-1:0]    count;
    } dna_result_t;

    dna_result_t due_results[$];

    // Shadow copy of the store and the match run.
    logic [CODE_W-1:0] base_codes [0:DEPTH-1];
    int                seq_len;
    int                run_pos;
    int                run_count;
    bit                run_done;

    int  error_count;
    int  beats_counted;
    int  idle_cycles;
    int  hold_left;
    bit  tx_idle;
    bit  rx_idle;

    // Clock: 10 time units per period.
    initial i_clk = 1'b0;
    always #5 i_clk = ~i_clk;

    task automatic report_error(input string msg);
        error_count++;
        if (error_count <= MAX_PRINTS)
            $display("ERROR @%0t: %s", $time, msg);
    endtask

    function automatic logic [CODE_W-1:0] code_for(input logic [CHAR_W-1:0] ch);
        case (ch)
            "C", "c": return 2'd1;
            "G", "g": return 2'd2;
            "T", "t": return 2'd3;
            default:  return 2'd0;
        endcase
    endfunction

    function automatic logic [LETTER_W-1:0] letter_for(input logic [CODE_W-1:0] code);
        case (code)
            2'd1:    return 7'h43;
            2'd2:    return 7'h47;
            2'd3:    return 7'h54;
            default: return 7'h41;
        endcase
    endfunction

    function automatic logic [CHAR_W-1:0] any_base_char();
        case ($urandom_range(0, 7))
            0: return "A";
            1: return "C";
            2: return "G";
            3: return "T";
            4: return "a";
            5: return "c";
            6: return "g";
            default: return "t";
        endcase
    endfunction

    function automatic dna_beat_t mk_beat(input t_action a, input int pos, input int ch,
                                          input bit comp, input bit desc,
                                          input bit first, input bit last);
        dna_beat_t b;
        b.act   = a;
        b.pos   = POS_W'(pos);
        b.ch    = CHAR_W'(ch);
        b.comp  = comp;
        b.desc  = desc;
        b.first = first;
        b.last  = last;
        return b;
    endfunction

    // Advance the shadow store by one accepted beat and queue what it yields.
    task automatic compute_dna_outcome(input dna_beat_t b);
        int                p;
        logic [CODE_W-1:0] code;
        dna_result_t       r;
        p = b.pos;
        case (b.act)
            ACT_WRITE: begin
                // Out-of-range writes are dropped; in-range ones extend the length when past its end.
                if (p >= 0 && p < DEPTH) begin
                    code = code_for(b.ch);
                    if (b.comp)
                        code = 2'd3 - code;
                    base_codes[p] = code;
                    if (p + 1 > seq_len)
                        seq_len = p + 1;
                end
            end
            ACT_READ: begin
                code = (p >= 0 && p < DEPTH) ? base_codes[p] : 2'd0;
                r.kind   = RES_READ;
                r.letter = letter_for(code);
                r.count  = '0;
                due_results.push_back(r);
            end
            ACT_CLEAR: begin
                seq_len = 0;
            end
            default: begin
                if (b.first) begin
                    run_pos   = p;
                    run_count = 0;
                    run_done  = 1'b0;
                end
                if (!run_done) begin
                    if (run_pos < 0 || run_pos >= seq_len) begin
                        run_done = 1'b1;
                    end else begin
                        code = base_codes[run_pos];
                        if (b.comp)
                            code = 2'd3 - code;
                        // Only the upper-case letter matches.
                        if (b.ch == {1'b0, letter_for(code)}) begin
                            run_count++;
                            run_pos = b.desc ? run_pos - 1 : run_pos + 1;
                        end else begin
                            run_done = 1'b1;
                        end
                    end
                end
                if (b.last) begin
                    run_done = 1'b1;
                    r.kind   = RES_MATCH;
                    r.letter = 7'h41;
                    r.count  = LEN_W'(run_count);
                    due_results.push_back(r);
                end
            end
        endcase
    endtask

    // Offer one beat from a falling edge and hold it until it is taken.
    task automatic send_beat(input dna_beat_t b);
        while (tx_idle && $urandom_range(99) < IDLE_PCT) begin
            i_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_action       <= b.act;
        i_position     <= b.pos;
        i_base_char    <= b.ch;
        i_complement   <= b.comp;
        i_descending   <= b.desc;
        i_first_of_run <= b.first;
        i_last_of_run  <= b.last;
        i_valid        <= 1'b1;
        @(posedge i_clk);
        while (o_stall !== 1'b0)
            @(posedge i_clk);
        beats_counted++;
        compute_dna_outcome(b);
        @(negedge i_clk);
    endtask

    task automatic drop_valid();
        i_valid <= 1'b0;
        @(negedge i_clk);
    endtask

    // Pause the sender until every queued result has come back.
    task automatic wait_results();
        drop_valid();
        while (due_results.size() != 0)
            @(negedge i_clk);
    endtask

    // Letter codes, case folding, complement, write/read range and ignored flags.
    task automatic test_codes_and_reads();
        send_beat(mk_beat(ACT_WRITE, 0, "a", 0, 0, 0, 0));
        send_beat(mk_beat(ACT_WRITE, 1, "C", 0, 0, 0, 0));
        send_beat(mk_beat(ACT_WRITE, 2, "g", 1, 0, 0, 0));
        send_beat(mk_beat(ACT_WRITE, 3, "T", 0, 0, 0, 0));
        // Unknown character stores A, complemented to T.
        send_beat(mk_beat(ACT_WRITE, 5, 8'hFF, 1, 0, 0, 0));
        // Negative position: drop the write.
        send_beat(mk_beat(ACT_WRITE, -1, "G", 0, 0, 0, 0));
        // Top entry, run flags set on a write must be ignored.
        send_beat(mk_beat(ACT_WRITE, DEPTH - 1, "c", 0, 1, 1, 1));
        send_beat(mk_beat(ACT_READ, 2, 8'h00, 1, 1, 1, 0));
        send_beat(mk_beat(ACT_READ, 5, 8'h00, 0, 0, 0, 0));
        send_beat(mk_beat(ACT_READ, -1, 8'hFF, 0, 0, 0, 1));
        // Clear keeps the stored codes.
        send_beat(mk_beat(ACT_CLEAR, 0, 8'h00, 0, 0, 0, 0));
        send_beat(mk_beat(ACT_READ, DEPTH - 1, 8'h00, 0, 0, 0, 0));
    endtask

    // Match runs: upward, downward on complement, lower-case query, sequence end,
    // start out of range, clear mid-run, and a last beat with no run open.
    task automatic test_match_rules();
        send_beat(mk_beat(ACT_WRITE, 4, "A", 0, 0, 0, 0));
        send_beat(mk_beat(ACT_MATCH, 0, "A", 0, 0, 1, 0));
        send_beat(mk_beat(ACT_MATCH, 0, "C", 0, 0, 0, 0));
        send_beat(mk_beat(ACT_MATCH, 0, "C", 0, 0, 0, 1));
        send_beat(mk_beat(ACT_MATCH, 4, "T", 1, 1, 1, 0));
        send_beat(mk_beat(ACT_MATCH, 0, "a", 1, 1, 0, 0));
        send_beat(mk_beat(ACT_MATCH, 0, "A", 1, 1, 0, 1));
        send_beat(mk_beat(ACT_MATCH, -1, "A", 0, 0, 1, 1));
        send_beat(mk_beat(ACT_MATCH, 3, "T", 0, 0, 1, 0));
        send_beat(mk_beat(ACT_MATCH, 0, "A", 0, 0, 0, 0));
        send_beat(mk_beat(ACT_MATCH, 0, "A", 0, 0, 0, 1));
        send_beat(mk_beat(ACT_MATCH, 0, "A", 0, 0, 1, 0));
        send_beat(mk_beat(ACT_CLEAR, 0, 8'h00, 0, 0, 0, 0));
        send_beat(mk_beat(ACT_MATCH, 0, "C", 0, 0, 0, 1));
        send_beat(mk_beat(ACT_MATCH, 7, "Z", 0, 0, 0, 1));
    endtask

    // Random segments: write bursts, match runs that mostly follow the stored
    // text, reads, clears and raw noise.
    task automatic run_random(input int n);
        int          target;
        int          pick;
        int          len;
        int          start;
        int          i;
        bit          comp;
        bit          desc;
        bit          c;
        logic [CODE_W-1:0] code;
        logic [CHAR_W-1:0] ch;
        target = beats_counted + n;
        while (beats_counted < target) begin
            pick = $urandom_range(0, 99);
            if (pick < 30) begin
                len   = $urandom_range(1, 16);
                start = ($urandom_range(0, 19) == 0) ? $urandom_range(DEPTH - 20, DEPTH - 1)
                                                     : $urandom_range(0, 63);
                for (i = 0; i < len; i++)
                    send_beat(mk_beat(ACT_WRITE, start + i,
                                      ($urandom_range(0, 9) == 0) ? $urandom_range(0, 255)
                                                                  : any_base_char(),
                                      $urandom_range(0, 1), $urandom_range(0, 1),
                                      $urandom_range(0, 1), $urandom_range(0, 1)));
            end else if (pick < 65) begin
                len  = $urandom_range(1, 12);
                comp = $urandom_range(0, 1);
                desc = $urandom_range(0, 1);
                if (seq_len > 0 && $urandom_range(0, 99) < 85) begin
                    start = $urandom_range(0, seq_len - 1);
                end else begin
                    case ($urandom_range(0, 2))
                        0:       start = -1;
                        1:       start = seq_len;
                        default: start = DEPTH - 1;
                    endcase
                end
                for (i = 0; i < len; i++) begin
                    if ($urandom_range(0, 99) < 3)
                        send_beat(mk_beat(ACT_CLEAR, $urandom_range(0, DEPTH - 1),
                                          $urandom_range(0, 255), 0, 0, 0, 0));
                    c = ($urandom_range(0, 9) == 0) ? ~comp : comp;
                    // Look ahead at the shadow store to follow the stored text.
                    if (i == 0) begin
                        run_pos  = start;
                    end
                    if ((i == 0 || !run_done) && run_pos >= 0 && run_pos < seq_len &&
                        $urandom_range(0, 99) < 85) begin
                        code = base_codes[run_pos];
                        if (c)
                            code = 2'd3 - code;
                        ch = {1'b0, letter_for(code)};
                    end else begin
                        ch = $urandom_range(0, 1) ? CHAR_W'($urandom_range(0, 255))
                                                  : any_base_char();
                    end
                    send_beat(mk_beat(ACT_MATCH, (i == 0) ? start : $urandom_range(0, 4095),
                                      ch, c, ($urandom_range(0, 19) == 0) ? ~desc : desc,
                                      i == 0, i == len - 1));
                end
            end else if (pick < 85) begin
                case ($urandom_range(0, 19))
                    0:       start = -1;
                    1, 2:    start = $urandom_range(0, DEPTH - 1);
                    default: start = $urandom_range(0, 127);
                endcase
                send_beat(mk_beat(ACT_READ, start, $urandom_range(0, 255),
                                  $urandom_range(0, 1), $urandom_range(0, 1),
                                  $urandom_range(0, 1), $urandom_range(0, 1)));
            end else if (pick < 90) begin
                send_beat(mk_beat(ACT_CLEAR, $urandom_range(0, DEPTH - 1),
                                  $urandom_range(0, 255), $urandom_range(0, 1),
                                  $urandom_range(0, 1), $urandom_range(0, 1),
                                  $urandom_range(0, 1)));
            end else begin
                send_beat(mk_beat(t_action'($urandom_range(0, 3)),
                                  $urandom_range(0, 19) == 0 ? -1 : $urandom_range(0, 4095),
                                  $urandom_range(0, 255), $urandom_range(0, 1),
                                  $urandom_range(0, 1), $urandom_range(0, 1),
                                  $urandom_range(0, 1)));
            end
        end
    endtask

    task automatic test_random_mix();
        tx_idle = 1'b1;
        rx_idle = 1'b1;
        run_random(1400);
    endtask

    // Hold the output off while reads keep coming so the queue fills and the
    // input stalls, then pause the sender until everything has drained.
    task automatic test_backpressure();
        int i;
        tx_idle   = 1'b0;
        hold_left = HOLD_CYCLES;
        for (i = 0; i < 24; i++)
            send_beat(mk_beat(ACT_READ, $urandom_range(0, 63), 8'h00, 0, 0, 0, 0));
        drop_valid();
        while (hold_left != 0)
            @(negedge i_clk);
        wait_results();
        tx_idle = 1'b1;
    endtask

    // Full rate on both sides, no random gaps; only the block's o_stall holds the sender.
    task automatic test_streaming();
        tx_idle = 1'b0;
        rx_idle = 1'b0;
        run_random(200);
        tx_idle = 1'b1;
        rx_idle = 1'b1;
    endtask

    // Receiver: random stall, or a counted hold-off when one is requested.
    initial begin
        i_stall = 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold_left > 0) begin
                i_stall <= 1'b1;
                hold_left--;
            end else if (rx_idle) begin
                i_stall <= ($urandom_range(99) < IDLE_PCT);
            end else begin
                i_stall <= 1'b0;
            end
        end
    end

    // Check each output beat against the oldest queued expectation.
    always @(posedge i_clk) begin
        dna_result_t want;
        if (i_rst_n && o_valid === 1'b1 && i_stall === 1'b0) begin
            if (due_results.size() == 0) begin
                report_error($sformatf("unexpected result kind %0d base %0d length %0d",
                                       o_result_kind, o_base_out, o_match_length));
            end else begin
                want = due_results.pop_front();
                if (o_result_kind !== want.kind)
                    report_error($sformatf("result_kind got %0d want %0d",
                                           o_result_kind, want.kind));
                if (o_base_out !== want.letter)
                    report_error($sformatf("base_out got %0d want %0d",
                                           o_base_out, want.letter));
                if (o_match_length !== want.count)
                    report_error($sformatf("match_length got %0d want %0d",
                                           o_match_length, want.count));
            end
        end
    end

    // Watchdog: end the run when nothing moves for too long.
    always @(posedge i_clk) begin
        if ((i_valid === 1'b1 && o_stall === 1'b0) || (o_valid === 1'b1 && i_stall === 1'b0))
            idle_cycles = 0;
        else
            idle_cycles++;
        if (idle_cycles >= STALL_LIMIT) begin
            $display("Regression FAIL");
            $finish;
        end
    end

    initial begin
        int k;
        i_rst_n        = 1'b0;
        i_valid        = 1'b0;
        i_action       = ACT_WRITE;
        i_position     = '0;
        i_base_char    = '0;
        i_complement   = 1'b0;
        i_descending   = 1'b0;
        i_first_of_run = 1'b0;
        i_last_of_run  = 1'b0;
        error_count    = 0;
        beats_counted  = 0;
        idle_cycles    = 0;
        hold_left      = 0;
        tx_idle        = 1'b1;
        rx_idle        = 1'b1;
        for (k = 0; k < DEPTH; k++)
            base_codes[k] = 2'd0;
        seq_len   = 0;
        run_pos   = 0;
        run_count = 0;
        run_done  = 1'b0;

        repeat (6) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        test_codes_and_reads();
        test_match_rules();
        test_random_mix();
        test_backpressure();
        test_streaming();

        // Drain, then allow for the pipeline latency.
        drop_valid();
        while (due_results.size() != 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (error_count == 0 && due_results.size() == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule

// ----- filelist.f -----
design/pdna_pkg.sv
design/pdna_front.sv
design/pdna_queue.sv
design/pdna_back.sv
design/packed_dna_store_match.sv
test/tb_packed_dna_store_match.sv
